/* hw/rtl/mlp_maturity_logit_defines.svh */
// assertion macros shared by the maturity logit rtl
// expects clk and rst_n in the scope of each use
`ifndef MLP_MATURITY_LOGIT_DEFINES_SVH
`define MLP_MATURITY_LOGIT_DEFINES_SVH

// same-cycle implication
`define MML_CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mml check failed");

// next-cycle implication
`define MML_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mml check failed");

`endif

/* hw/rtl/mml_pkg.sv */
// types, tables and fixed point helpers for the maturity logit block
// no dependencies
`timescale 1ns / 1ps
package mml_pkg;

  localparam int NODE_MAX = 16;
  localparam int ACC_W    = 42;
  localparam int OPND_W   = 23;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_AGE,
    SRC_ACT2,
    SRC_ACT1
  } mml_src_t;

  typedef enum logic [1:0] {
    LYR_HID2,
    LYR_HID1,
    LYR_OUT
  } mml_layer_t;

  typedef struct packed {
    logic       wr;
    logic       cap;
    logic       vld;
    logic [7:0] addr;
    mml_src_t   src;
    logic [3:0] idx;
    logic       first;
    logic       last;
    mml_layer_t layer;
    logic [3:0] node;
    logic       ld_eval;
    logic       ld_ack;
  } mml_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mml_sts_t;

  localparam logic [15:0] SIG_TAB [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565, 16'd62428,
    16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269, 16'd65374, 16'd65438,
    16'd65476, 16'd65500, 16'd65514
  };

  localparam logic [11:0] LG_TAB [17] = '{
    12'd2839, 12'd1942, 12'd1283, 12'd825, 12'd520, 12'd323, 12'd199, 12'd122,
    12'd74, 12'd45, 12'd28, 12'd17, 12'd10, 12'd6, 12'd4, 12'd2, 12'd1
  };

  // rising table, step of 2048 in q.12
  function automatic logic [15:0] sig_interp(input logic [4:0] idx, input logic [10:0] fr);
    logic [4:0]  nx;
    logic [15:0] d;
    logic [31:0] pr;
    nx = (idx == 5'd16) ? 5'd16 : idx + 5'd1;
    d  = SIG_TAB[nx] - SIG_TAB[idx];
    pr = 32'(d) * 32'(fr) + 32'd1024;
    return SIG_TAB[idx] + pr[26:11];
  endfunction

  // falling table, same grid
  function automatic logic [11:0] lg_interp(input logic [4:0] idx, input logic [10:0] fr);
    logic [4:0]  nx;
    logic [11:0] d;
    logic [31:0] pr;
    nx = (idx == 5'd16) ? 5'd16 : idx + 5'd1;
    d  = LG_TAB[idx] - LG_TAB[nx];
    pr = 32'(d) * 32'(fr) + 32'd1024;
    return LG_TAB[idx] - pr[22:11];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) return 24'sd8388607;
    if (v < -27'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

endpackage

/* hw/rtl/mml_ctrl.sv */
// sequencer for the maturity logit block: walks the weight store per layer
// uses mml_pkg command and status structs
`timescale 1ns / 1ps
`include "mlp_maturity_logit_defines.svh"
module mml_ctrl #(
  parameter int SECOND_LAYER_NODES = 8,
  parameter int FIRST_LAYER_NODES  = 8,
  parameter int SEGMENT_COUNT      = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  input  logic [3:0]       in_cohort_segment,
  output logic             in_stall,
  input  mml_pkg::mml_sts_t sts,
  output mml_pkg::mml_cmd_t cmd
);

  localparam int IN_LEN  = 1 + SEGMENT_COUNT;
  localparam int B2_I    = SECOND_LAYER_NODES * IN_LEN;
  localparam int W1_I    = B2_I + SECOND_LAYER_NODES;
  localparam int B1_I    = W1_I + FIRST_LAYER_NODES * SECOND_LAYER_NODES;
  localparam int W0_I    = B1_I + FIRST_LAYER_NODES;
  localparam int B0_I    = W0_I + FIRST_LAYER_NODES;
  localparam logic [7:0] LEN_A   = 8'(IN_LEN % 256);
  localparam logic [7:0] BASE_B2 = 8'(B2_I % 256);
  localparam logic [7:0] BASE_W1 = 8'(W1_I % 256);
  localparam logic [7:0] BASE_B1 = 8'(B1_I % 256);
  localparam logic [7:0] BASE_W0 = 8'(W0_I % 256);
  localparam logic [7:0] BASE_B0 = 8'(B0_I % 256);
  localparam logic [4:0] N2_T    = 5'(SECOND_LAYER_NODES);
  localparam logic [4:0] N1_T    = 5'(FIRST_LAYER_NODES);
  localparam logic [3:0] N2_LAST = 4'(SECOND_LAYER_NODES - 1);
  localparam logic [3:0] N1_LAST = 4'(FIRST_LAYER_NODES - 1);
  localparam logic [5:0] SEG_MAX = 6'(SEGMENT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WACK, ST_L2, ST_L2_WAIT, ST_L1, ST_L1_WAIT, ST_OUTL, ST_OUT_WAIT
  } state_t;

  state_t               state_r;
  logic [3:0]           node_r;
  logic [4:0]           term_r;
  logic [7:0]           base_r;
  logic [7:0]           waddr_r;
  logic [3:0]           seg_r;
  logic                 seg_ok_r;
  logic                 mvld_r;
  logic [7:0]           maddr_r;
  mml_pkg::mml_src_t    msrc_r;
  logic [3:0]           midx_r;
  logic                 mfirst_r;
  logic                 mlast_r;
  mml_pkg::mml_layer_t  mlayer_r;
  logic [3:0]           mnode_r;
  logic                 accept;
  logic                 drained;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign drained  = !sts.pipe_busy && !mvld_r;

  always_comb begin
    cmd.wr      = accept && !in_command;
    cmd.cap     = accept && in_command;
    cmd.vld     = mvld_r;
    cmd.addr    = maddr_r;
    cmd.src     = msrc_r;
    cmd.idx     = midx_r;
    cmd.first   = mfirst_r;
    cmd.last    = mlast_r;
    cmd.layer   = mlayer_r;
    cmd.node    = mnode_r;
    cmd.ld_eval = (state_r == ST_OUT_WAIT) && drained && sts.out_free;
    cmd.ld_ack  = (state_r == ST_WACK) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mvld_r  <= 1'b0;
      node_r  <= '0;
      term_r  <= '0;
    end else begin
      mvld_r   <= 1'b0;
      mfirst_r <= 1'b0;
      mlast_r  <= 1'b0;
      mnode_r  <= node_r;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_command) begin
              seg_r    <= in_cohort_segment;
              seg_ok_r <= (in_cohort_segment != 4'd0) &&
                          ({2'b00, in_cohort_segment} <= SEG_MAX);
              node_r   <= '0;
              term_r   <= '0;
              base_r   <= '0;
              state_r  <= ST_L2;
            end else begin
              state_r <= ST_WACK;
            end
          end
        end
        ST_WACK: begin
          if (sts.out_free) state_r <= ST_IDLE;
        end
        ST_L2: begin
          mvld_r   <= 1'b1;
          mlayer_r <= mml_pkg::LYR_HID2;
          midx_r   <= '0;
          case (term_r)
            5'd0: begin
              maddr_r  <= base_r;
              msrc_r   <= mml_pkg::SRC_AGE;
              mfirst_r <= 1'b1;
              term_r   <= 5'd1;
            end
            5'd1: begin
              // an absent segment still reads a written word, scaled by zero
              maddr_r <= seg_ok_r ? base_r + {4'b0000, seg_r} : base_r;
              msrc_r  <= seg_ok_r ? mml_pkg::SRC_ONE : mml_pkg::SRC_ZERO;
              term_r  <= 5'd2;
            end
            default: begin
              maddr_r <= BASE_B2 + {4'b0000, node_r};
              msrc_r  <= mml_pkg::SRC_ONE;
              mlast_r <= 1'b1;
              term_r  <= '0;
              base_r  <= base_r + LEN_A;
              if (node_r == N2_LAST) begin
                node_r  <= '0;
                waddr_r <= BASE_W1;
                state_r <= ST_L2_WAIT;
              end else begin
                node_r <= node_r + 4'd1;
              end
            end
          endcase
        end
        ST_L2_WAIT: begin
          if (drained) state_r <= ST_L1;
        end
        ST_L1: begin
          mvld_r   <= 1'b1;
          mlayer_r <= mml_pkg::LYR_HID1;
          midx_r   <= term_r[3:0];
          if (term_r < N2_T) begin
            maddr_r  <= waddr_r;
            msrc_r   <= mml_pkg::SRC_ACT2;
            mfirst_r <= (term_r == 5'd0);
            waddr_r  <= waddr_r + 8'd1;
            term_r   <= term_r + 5'd1;
          end else begin
            maddr_r <= BASE_B1 + {4'b0000, node_r};
            msrc_r  <= mml_pkg::SRC_ONE;
            mlast_r <= 1'b1;
            term_r  <= '0;
            if (node_r == N1_LAST) begin
              node_r  <= '0;
              state_r <= ST_L1_WAIT;
            end else begin
              node_r <= node_r + 4'd1;
            end
          end
        end
        ST_L1_WAIT: begin
          if (drained) state_r <= ST_OUTL;
        end
        ST_OUTL: begin
          mvld_r   <= 1'b1;
          mlayer_r <= mml_pkg::LYR_OUT;
          midx_r   <= term_r[3:0];
          if (term_r < N1_T) begin
            maddr_r  <= BASE_W0 + {3'b000, term_r};
            msrc_r   <= mml_pkg::SRC_ACT1;
            mfirst_r <= (term_r == 5'd0);
            term_r   <= term_r + 5'd1;
          end else begin
            maddr_r <= BASE_B0;
            msrc_r  <= mml_pkg::SRC_ONE;
            mlast_r <= 1'b1;
            term_r  <= '0;
            state_r <= ST_OUT_WAIT;
          end
        end
        ST_OUT_WAIT: begin
          if (drained && sts.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `MML_CHK_IMPL(a_ld_drained, cmd.ld_eval, !sts.pipe_busy && !mvld_r)
  `MML_CHK_IMPL(a_first_not_last, mvld_r && mlast_r, !mfirst_r)
  `MML_CHK_IMPL(a_act2_in_l1, mvld_r && (msrc_r == mml_pkg::SRC_ACT2),
                mlayer_r == mml_pkg::LYR_HID1)

endmodule

/* hw/rtl/mml_datapath.sv */
// weight store, shared multiply-accumulate, sigmoid and log unit, result register
// uses mml_pkg tables, helpers and command and status structs
`timescale 1ns / 1ps
`include "mlp_maturity_logit_defines.svh"
module mml_datapath #(
  parameter int AGE_LIMIT = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mml_pkg::mml_cmd_t        cmd,
  output mml_pkg::mml_sts_t        sts,
  input  logic [7:0]               in_weight_addr,
  input  logic signed [15:0]       in_weight_value,
  input  logic [4:0]               in_age,
  input  logic signed [23:0]       in_cohort_deviation,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [23:0]       out_logit_out,
  output logic [15:0]              out_maturity_prob,
  output logic signed [23:0]       out_log_mature_prob,
  output logic signed [23:0]       out_log_immature_prob,
  output logic                     out_is_eval_result
);

  localparam logic [6:0] AGE_LIM = 7'(AGE_LIMIT);
  localparam logic [4:0] AGE_TOP = 5'(AGE_LIMIT - 1);

  logic [15:0]          mem [256];
  logic [15:0]          mem_q_r;

  logic [4:0]           age_r;
  logic signed [23:0]   dev_r;

  logic [15:0]          a2_r [mml_pkg::NODE_MAX];
  logic [15:0]          a1_r [mml_pkg::NODE_MAX];

  logic                 s1_vld_r;
  mml_pkg::mml_src_t    s1_src_r;
  logic [3:0]           s1_idx_r;
  logic                 s1_first_r;
  logic                 s1_last_r;
  mml_pkg::mml_layer_t  s1_layer_r;
  logic [3:0]           s1_node_r;

  logic                 s2_vld_r;
  logic signed [39:0]   prod_r;
  logic                 s2_first_r;
  logic                 s2_last_r;
  mml_pkg::mml_layer_t  s2_layer_r;
  logic [3:0]           s2_node_r;

  logic signed [mml_pkg::ACC_W-1:0] acc_r;
  logic signed [mml_pkg::ACC_W-1:0] sum_full;
  logic signed [mml_pkg::ACC_W-1:0] sum_rnd;

  logic                 rnd_vld_r;
  logic signed [25:0]   rnd_x_r;
  mml_pkg::mml_layer_t  rnd_layer_r;
  logic [3:0]           rnd_node_r;

  logic                 sa_vld_r;
  mml_pkg::mml_layer_t  sa_layer_r;
  logic [3:0]           sa_node_r;
  logic                 sa_neg_r;
  logic [4:0]           sa_idx_r;
  logic [10:0]          sa_fr_r;
  logic signed [23:0]   sa_x_r;

  logic signed [23:0]   fin_logit_r;
  logic [15:0]          fin_p_r;
  logic signed [23:0]   fin_lm_r;
  logic signed [23:0]   fin_li_r;

  logic                 out_valid_r;

  logic [mml_pkg::OPND_W-1:0] opnd;
  logic signed [26:0]   x27;
  logic signed [23:0]   logit_sat;
  logic [26:0]          mag;
  logic [15:0]          sg;
  logic [16:0]          p17;
  logic [11:0]          g;
  logic signed [26:0]   xg;
  logic signed [26:0]   g27;
  logic signed [26:0]   lm27;
  logic signed [26:0]   li27;

  // weight store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[in_weight_addr] <= in_weight_value;
    mem_q_r <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      age_r <= ({2'b00, in_age} >= AGE_LIM) ? AGE_TOP : in_age;
      dev_r <= in_cohort_deviation;
    end
  end

  // operands scaled to q.16 so every layer rounds the same way
  always_comb begin
    case (s1_src_r)
      mml_pkg::SRC_ZERO: opnd = '0;
      mml_pkg::SRC_ONE:  opnd = mml_pkg::OPND_W'(32'h10000);
      mml_pkg::SRC_AGE:  opnd = {2'b00, age_r, 16'h0000};
      mml_pkg::SRC_ACT2: opnd = {7'd0, a2_r[s1_idx_r]};
      mml_pkg::SRC_ACT1: opnd = {7'd0, a1_r[s1_idx_r]};
      default:           opnd = '0;
    endcase
  end

  assign sum_full = (s2_first_r ? '0 : acc_r) + mml_pkg::ACC_W'(prod_r);
  assign sum_rnd  = (sum_full + mml_pkg::ACC_W'(32768)) >>> 16;

  always_comb begin
    logit_sat = mml_pkg::sat24(27'(rnd_x_r) + 27'(dev_r));
    if (rnd_layer_r == mml_pkg::LYR_OUT) x27 = 27'(logit_sat);
    else x27 = 27'(rnd_x_r);
    mag = x27[26] ? 27'(-x27) : 27'(x27);
  end

  always_comb begin
    sg   = mml_pkg::sig_interp(sa_idx_r, sa_fr_r);
    p17  = sa_neg_r ? (17'h10000 - {1'b0, sg}) : {1'b0, sg};
    g    = mml_pkg::lg_interp(sa_idx_r, sa_fr_r);
    xg   = 27'(sa_x_r);
    g27  = 27'(signed'({1'b0, g}));
    lm27 = sa_neg_r ? (xg - g27) : -g27;
    li27 = sa_neg_r ? -g27 : -(xg + g27);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      rnd_vld_r <= 1'b0;
      sa_vld_r  <= 1'b0;
    end else begin
      s1_vld_r  <= cmd.vld;
      s2_vld_r  <= s1_vld_r;
      rnd_vld_r <= s2_vld_r && s2_last_r;
      sa_vld_r  <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_src_r   <= cmd.src;
    s1_idx_r   <= cmd.idx;
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last;
    s1_layer_r <= cmd.layer;
    s1_node_r  <= cmd.node;

    prod_r     <= signed'(mem_q_r) * signed'({1'b0, opnd});
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_layer_r <= s1_layer_r;
    s2_node_r  <= s1_node_r;

    if (s2_vld_r) acc_r <= sum_full;
    rnd_x_r     <= sum_rnd[25:0];
    rnd_layer_r <= s2_layer_r;
    rnd_node_r  <= s2_node_r;

    sa_layer_r <= rnd_layer_r;
    sa_node_r  <= rnd_node_r;
    sa_neg_r   <= x27[26];
    sa_x_r     <= x27[23:0];
    if (|mag[26:15]) begin
      sa_idx_r <= 5'd16;
      sa_fr_r  <= '0;
    end else begin
      sa_idx_r <= {1'b0, mag[14:11]};
      sa_fr_r  <= mag[10:0];
    end

    if (sa_vld_r) begin
      case (sa_layer_r)
        mml_pkg::LYR_HID2: a2_r[sa_node_r] <= p17[15:0];
        mml_pkg::LYR_HID1: a1_r[sa_node_r] <= p17[15:0];
        default: begin
          fin_logit_r <= sa_x_r;
          fin_p_r     <= p17[15:0];
          fin_lm_r    <= mml_pkg::sat24(lm27);
          fin_li_r    <= mml_pkg::sat24(li27);
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_eval || cmd.ld_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_eval) begin
      out_logit_out         <= fin_logit_r;
      out_maturity_prob     <= fin_p_r;
      out_log_mature_prob   <= fin_lm_r;
      out_log_immature_prob <= fin_li_r;
      out_is_eval_result    <= 1'b1;
    end else if (cmd.ld_ack) begin
      out_logit_out         <= '0;
      out_maturity_prob     <= '0;
      out_log_mature_prob   <= '0;
      out_log_immature_prob <= '0;
      out_is_eval_result    <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.pipe_busy = s1_vld_r || s2_vld_r || rnd_vld_r || sa_vld_r;

  `MML_CHK_IMPL(a_no_overwrite, cmd.ld_eval || cmd.ld_ack, !(out_valid_r && out_stall))
  `MML_CHK_IMPL(a_act2_quiet, s1_vld_r && (s1_src_r == mml_pkg::SRC_ACT2),
                !(sa_vld_r && (sa_layer_r == mml_pkg::LYR_HID2)))
  `MML_CHK_NEXT(a_ack_zero, cmd.ld_ack, !out_is_eval_result && (out_logit_out == 24'sd0))

endmodule

/* hw/rtl/mlp_maturity_logit.sv */
// Maturity logit network: two sigmoid hidden layers and a linear output node.
// Input requests carry a command: a write stores one Q4.12 weight word at
// weight_addr, an evaluate request runs the network on age, cohort segment
// and deviation. Every request returns exactly one result request; a write
// returns an all-zero acknowledgement with is_eval_result low.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. in_stall is high from acceptance until the result has been
// placed in the output register, so one request is in work at a time while
// an earlier result may still wait at the output.
// A write acknowledgement is loaded once the sequencer has passed its
// acknowledge state and the output register is free; a new request is
// accepted only after that. An evaluate result is loaded after the single
// multiply-accumulate unit has read the weights of all three layers from
// the store, one weight per cycle, with a wait after each layer until the
// pipeline has drained; the next request can be accepted in the cycle after.
// A stalled result holds in the output register; a finishing request waits
// there until the register is free. Reset clears control state only; the
// weight store holds no defined value until written.
`timescale 1ns / 1ps
module mlp_maturity_logit #(
  parameter int SECOND_LAYER_NODES = 8,
  parameter int FIRST_LAYER_NODES  = 8,
  parameter int SEGMENT_COUNT      = 15,
  parameter int AGE_LIMIT          = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_weight_addr,
  input  logic signed [15:0] in_weight_value,
  input  logic [3:0]         in_cohort_segment,
  input  logic [4:0]         in_age,
  input  logic signed [23:0] in_cohort_deviation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_logit_out,
  output logic [15:0]        out_maturity_prob,
  output logic signed [23:0] out_log_mature_prob,
  output logic signed [23:0] out_log_immature_prob,
  output logic               out_is_eval_result
);

  mml_pkg::mml_cmd_t cmd;
  mml_pkg::mml_sts_t sts;

  mml_ctrl #(
    .SECOND_LAYER_NODES (SECOND_LAYER_NODES),
    .FIRST_LAYER_NODES  (FIRST_LAYER_NODES),
    .SEGMENT_COUNT      (SEGMENT_COUNT)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_command        (in_command),
    .in_cohort_segment (in_cohort_segment),
    .in_stall          (in_stall),
    .sts               (sts),
    .cmd               (cmd)
  );

  mml_datapath #(
    .AGE_LIMIT (AGE_LIMIT)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_weight_addr        (in_weight_addr),
    .in_weight_value       (in_weight_value),
    .in_age                (in_age),
    .in_cohort_deviation   (in_cohort_deviation),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_logit_out         (out_logit_out),
    .out_maturity_prob     (out_maturity_prob),
    .out_log_mature_prob   (out_log_mature_prob),
    .out_log_immature_prob (out_log_immature_prob),
    .out_is_eval_result    (out_is_eval_result)
  );

endmodule
